FILE: design/bgpc_pkg.sv
package bgpc_pkg;

	localparam int MAX_WIDTH_DEF  = 4096;
	localparam int MAX_HEIGHT_DEF = 4096;

	localparam int COLOR_W   = 24;
	localparam int CHAN_W    = 8;
	localparam int SIZE_W    = 13;
	localparam int COORD_W   = 12;
	localparam int CFG_IDX_W = 3;
	localparam int NUM_CH    = 3;
	localparam int NUM_CORN  = 4;

	// one quotient bit per divider stage
	localparam int DIV_STEPS = CHAN_W;
	// clamp, weights, corner products, partial sums, full sum, then the divider
	localparam int NUM_STAGES = 5 + DIV_STEPS;

	localparam logic [CFG_IDX_W-1:0] REG_TOP_LEFT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_RIGHT    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_LEFT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_RIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT       = 3'd5;

	localparam logic [COLOR_W-1:0] RST_TOP_LEFT     = 24'hFF0000;
	localparam logic [COLOR_W-1:0] RST_TOP_RIGHT    = 24'h0000FF;
	localparam logic [COLOR_W-1:0] RST_BOTTOM_LEFT  = 24'hFFFF00;
	localparam logic [COLOR_W-1:0] RST_BOTTOM_RIGHT = 24'h00FF00;
	localparam logic [SIZE_W-1:0]  RST_WIDTH        = 13'd640;
	localparam logic [SIZE_W-1:0]  RST_HEIGHT       = 13'd480;

	typedef struct packed {
		logic [COLOR_W-1:0] tl;
		logic [COLOR_W-1:0] tr;
		logic [COLOR_W-1:0] bl;
		logic [COLOR_W-1:0] br;
	} corners_t;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

endpackage

FILE: design/bgpc_ifs.sv
interface bgpc_pixel_if;
	logic                           valid;
	logic                           ready;
	logic [bgpc_pkg::COORD_W-1:0]   pixel_x;
	logic [bgpc_pkg::COORD_W-1:0]   pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface bgpc_color_if;
	logic                          valid;
	logic                          ready;
	logic [bgpc_pkg::CHAN_W-1:0]   red;
	logic [bgpc_pkg::CHAN_W-1:0]   green;
	logic [bgpc_pkg::CHAN_W-1:0]   blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

interface bgpc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [bgpc_pkg::CFG_IDX_W-1:0]  index;
	logic [bgpc_pkg::COLOR_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/bgpc_cfg_regs.sv
module bgpc_cfg_regs #(
	parameter int MAX_WIDTH  = bgpc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bgpc_pkg::MAX_HEIGHT_DEF,
	parameter int WS         = $clog2(MAX_WIDTH),
	parameter int HS         = $clog2(MAX_HEIGHT)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  bgpc_pkg::cfg_idx_t             wr_index,
	input  logic [bgpc_pkg::COLOR_W-1:0]   wr_data,
	output bgpc_pkg::corners_t             corners,
	output logic [WS-1:0]                  span_w,
	output logic [HS-1:0]                  span_h
);

	bgpc_pkg::corners_t               corners_q;
	logic [bgpc_pkg::SIZE_W-1:0]      width_q;
	logic [bgpc_pkg::SIZE_W-1:0]      height_q;
	logic [31:0]                      wsz;
	logic [31:0]                      hsz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corners_q.tl <= bgpc_pkg::RST_TOP_LEFT;
			corners_q.tr <= bgpc_pkg::RST_TOP_RIGHT;
			corners_q.bl <= bgpc_pkg::RST_BOTTOM_LEFT;
			corners_q.br <= bgpc_pkg::RST_BOTTOM_RIGHT;
			width_q      <= bgpc_pkg::RST_WIDTH;
			height_q     <= bgpc_pkg::RST_HEIGHT;
		end else if (wr_en) begin
			unique case (wr_index)
				bgpc_pkg::REG_TOP_LEFT:     corners_q.tl <= wr_data;
				bgpc_pkg::REG_TOP_RIGHT:    corners_q.tr <= wr_data;
				bgpc_pkg::REG_BOTTOM_LEFT:  corners_q.bl <= wr_data;
				bgpc_pkg::REG_BOTTOM_RIGHT: corners_q.br <= wr_data;
				bgpc_pkg::REG_WIDTH:        width_q  <= wr_data[bgpc_pkg::SIZE_W-1:0];
				bgpc_pkg::REG_HEIGHT:       height_q <= wr_data[bgpc_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// size of zero acts as one, size above the maximum acts as the maximum
	always_comb begin
		wsz = (width_q == '0) ? 32'd1 : 32'(width_q);
		if (wsz > 32'(MAX_WIDTH))
			wsz = 32'(MAX_WIDTH);
		hsz = (height_q == '0) ? 32'd1 : 32'(height_q);
		if (hsz > 32'(MAX_HEIGHT))
			hsz = 32'(MAX_HEIGHT);
	end

	assign corners = corners_q;
	assign span_w  = WS'(wsz - 32'd1);
	assign span_h  = HS'(hsz - 32'd1);

endmodule

FILE: design/bgpc_weights.sv
module bgpc_weights #(
	parameter int WS    = 12,
	parameter int HS    = 12,
	parameter int DEN_W = WS + HS
) (
	input  logic                                        clk,
	input  logic                                        en,
	input  logic [bgpc_pkg::COORD_W-1:0]                pixel_x,
	input  logic [bgpc_pkg::COORD_W-1:0]                pixel_y,
	input  logic [WS-1:0]                               span_w,
	input  logic [HS-1:0]                               span_h,
	output logic [bgpc_pkg::NUM_CORN-1:0][DEN_W-1:0]    wgt,
	output logic [DEN_W-1:0]                            den
);

	logic [WS-1:0] wd;
	logic [HS-1:0] hd;
	logic [WS-1:0] cx;
	logic [HS-1:0] cy;

	logic [WS-1:0] cx_s1;
	logic [HS-1:0] cy_s1;
	logic [WS-1:0] ax_s1;
	logic [HS-1:0] by_s1;
	logic [WS-1:0] wd_s1;
	logic [HS-1:0] hd_s1;

	logic [bgpc_pkg::NUM_CORN-1:0][DEN_W-1:0] wgt_s2;
	logic [DEN_W-1:0]                         den_s2;

	// clamp to the span; a zero span divides by one and keeps the first end
	always_comb begin
		wd = (span_w == '0) ? WS'(1) : span_w;
		hd = (span_h == '0) ? HS'(1) : span_h;
		cx = (32'(pixel_x) > 32'(span_w)) ? span_w : WS'(pixel_x);
		cy = (32'(pixel_y) > 32'(span_h)) ? span_h : HS'(pixel_y);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s1 <= cx;
			cy_s1 <= cy;
			ax_s1 <= wd - cx;
			by_s1 <= hd - cy;
			wd_s1 <= wd;
			hd_s1 <= hd;
		end
	end

	// corner order: top left, top right, bottom left, bottom right
	always_ff @(posedge clk) begin
		if (en) begin
			wgt_s2[0] <= DEN_W'(ax_s1) * DEN_W'(by_s1);
			wgt_s2[1] <= DEN_W'(cx_s1) * DEN_W'(by_s1);
			wgt_s2[2] <= DEN_W'(ax_s1) * DEN_W'(cy_s1);
			wgt_s2[3] <= DEN_W'(cx_s1) * DEN_W'(cy_s1);
			den_s2    <= DEN_W'(wd_s1) * DEN_W'(hd_s1);
		end
	end

	assign wgt = wgt_s2;
	assign den = den_s2;

endmodule

FILE: design/bgpc_blend.sv
module bgpc_blend #(
	parameter int DEN_W = 24,
	parameter int NUM_W = DEN_W + bgpc_pkg::CHAN_W
) (
	input  logic                                        clk,
	input  logic                                        en,
	input  bgpc_pkg::corners_t                          corners,
	input  logic [bgpc_pkg::NUM_CORN-1:0][DEN_W-1:0]    wgt,
	input  logic [DEN_W-1:0]                            den,
	output logic [bgpc_pkg::NUM_CH-1:0][NUM_W-1:0]      num,
	output logic [DEN_W-1:0]                            den_out
);

	logic [bgpc_pkg::NUM_CORN-1:0][bgpc_pkg::COLOR_W-1:0] cc;

	logic [NUM_W-1:0] prod_s3 [bgpc_pkg::NUM_CH][bgpc_pkg::NUM_CORN];
	logic [DEN_W-1:0] den_s3;
	logic [NUM_W-1:0] top_s4 [bgpc_pkg::NUM_CH];
	logic [NUM_W-1:0] bot_s4 [bgpc_pkg::NUM_CH];
	logic [DEN_W-1:0] den_s4;
	logic [bgpc_pkg::NUM_CH-1:0][NUM_W-1:0] num_s5;
	logic [DEN_W-1:0] den_s5;

	assign cc = {corners.br, corners.bl, corners.tr, corners.tl};

	// channel 0 is red in the top byte
	always_ff @(posedge clk) begin
		if (en) begin
			den_s3 <= den;
			for (int c = 0; c < bgpc_pkg::NUM_CH; c++) begin
				for (int i = 0; i < bgpc_pkg::NUM_CORN; i++) begin
					prod_s3[c][i] <= NUM_W'(cc[i][(bgpc_pkg::NUM_CH-1-c)*bgpc_pkg::CHAN_W +:
						bgpc_pkg::CHAN_W]) * NUM_W'(wgt[i]);
				end
			end
		end
	end

	// fold the rounding offset (half the divisor) into the bottom pair
	always_ff @(posedge clk) begin
		if (en) begin
			den_s4 <= den_s3;
			for (int c = 0; c < bgpc_pkg::NUM_CH; c++) begin
				top_s4[c] <= prod_s3[c][0] + prod_s3[c][1];
				bot_s4[c] <= prod_s3[c][2] + prod_s3[c][3] + NUM_W'(den_s3 >> 1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s5 <= den_s4;
			for (int c = 0; c < bgpc_pkg::NUM_CH; c++)
				num_s5[c] <= top_s4[c] + bot_s4[c];
		end
	end

	assign num     = num_s5;
	assign den_out = den_s5;

endmodule

FILE: design/bgpc_div.sv
module bgpc_div #(
	parameter int DEN_W = 24,
	parameter int NUM_W = DEN_W + bgpc_pkg::CHAN_W
) (
	input  logic                                             clk,
	input  logic                                             en,
	input  logic [bgpc_pkg::NUM_CH-1:0][NUM_W-1:0]           num,
	input  logic [DEN_W-1:0]                                 den,
	output logic [bgpc_pkg::NUM_CH-1:0][bgpc_pkg::CHAN_W-1:0] quo
);

	localparam int STEPS = bgpc_pkg::DIV_STEPS;

	logic [NUM_W-1:0]            rem_s [STEPS-1][bgpc_pkg::NUM_CH];
	logic [DEN_W-1:0]            den_s [STEPS-1];
	logic [bgpc_pkg::CHAN_W-1:0] quo_s [STEPS][bgpc_pkg::NUM_CH];

	// restoring division, most significant quotient bit first; the sum is
	// below 256 times the divisor so eight bits always hold the quotient
	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic [NUM_W-1:0]            rin [bgpc_pkg::NUM_CH];
		logic [bgpc_pkg::CHAN_W-1:0] qin [bgpc_pkg::NUM_CH];
		logic [DEN_W-1:0]            din;
		logic [NUM_W-1:0]            dsh;
		logic [bgpc_pkg::NUM_CH-1:0] ge;

		if (k == 0) begin : g_first
			assign din = den;
			for (genvar c = 0; c < bgpc_pkg::NUM_CH; c++) begin : g_ch
				assign rin[c] = num[c];
				assign qin[c] = '0;
			end
		end else begin : g_next
			assign din = den_s[k-1];
			for (genvar c = 0; c < bgpc_pkg::NUM_CH; c++) begin : g_ch
				assign rin[c] = rem_s[k-1][c];
				assign qin[c] = quo_s[k-1][c];
			end
		end

		assign dsh = NUM_W'(din) << (STEPS - 1 - k);

		for (genvar c = 0; c < bgpc_pkg::NUM_CH; c++) begin : g_cmp
			assign ge[c] = (rin[c] >= dsh);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int c = 0; c < bgpc_pkg::NUM_CH; c++)
					quo_s[k][c] <= {qin[c][bgpc_pkg::CHAN_W-2:0], ge[c]};
			end
		end

		// the last step needs no remainder
		if (k < STEPS - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					den_s[k] <= din;
					for (int c = 0; c < bgpc_pkg::NUM_CH; c++)
						rem_s[k][c] <= ge[c] ? (rin[c] - dsh) : rin[c];
				end
			end
		end
	end

	for (genvar c = 0; c < bgpc_pkg::NUM_CH; c++) begin : g_out
		assign quo[c] = quo_s[STEPS-1][c];
	end

endmodule

FILE: design/bilinear_gradient_pixel_color_unit.sv
// Channel  Dir  Payload                          Handshake
// pixel    in   pixel_x[11:0], pixel_y[11:0]     valid/ready
// color    out  red[7:0], green[7:0], blue[7:0]  valid/ready
// cfg      in   index[2:0], data[23:0]           valid/ready, ready always high
//
// Thirteen pipeline stages: clamp, weights, corner products, two adder
// stages, then eight restoring divider stages, one quotient bit each.
// One request per cycle sustained while color does not stall.
// A skid register behind the last stage holds one result when color stalls;
// while it is full the whole pipeline freezes and pixel.ready is low.
// arst_n clears valid bits and loads register defaults; config takes effect
// in the cycle after the write.
module bilinear_gradient_pixel_color_unit #(
	parameter int MAX_WIDTH  = bgpc_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = bgpc_pkg::MAX_HEIGHT_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	bgpc_pixel_if.sink      pixel,
	bgpc_color_if.source    color,
	bgpc_cfg_if.sink        cfg
);

	localparam int WS    = $clog2(MAX_WIDTH);
	localparam int HS    = $clog2(MAX_HEIGHT);
	localparam int DEN_W = WS + HS;
	localparam int NUM_W = DEN_W + bgpc_pkg::CHAN_W;
	localparam int NST   = bgpc_pkg::NUM_STAGES;

	bgpc_pkg::corners_t corners;
	logic [WS-1:0]      span_w;
	logic [HS-1:0]      span_h;

	logic [bgpc_pkg::NUM_CORN-1:0][DEN_W-1:0]       wgt;
	logic [DEN_W-1:0]                               den_w;
	logic [bgpc_pkg::NUM_CH-1:0][NUM_W-1:0]         num;
	logic [DEN_W-1:0]                               den_b;
	logic [bgpc_pkg::NUM_CH-1:0][bgpc_pkg::CHAN_W-1:0] quo;

	logic [NST-1:0]                                 vld_q;
	logic                                           skid_vld_q;
	logic [bgpc_pkg::NUM_CH-1:0][bgpc_pkg::CHAN_W-1:0] skid_rgb_q;
	logic                                           en;

	assign cfg.ready = 1'b1;

	bgpc_cfg_regs #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.WS        (WS),
		.HS        (HS)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cfg.valid),
		.wr_index(cfg.index),
		.wr_data (cfg.data),
		.corners (corners),
		.span_w  (span_w),
		.span_h  (span_h)
	);

	bgpc_weights #(
		.WS   (WS),
		.HS   (HS),
		.DEN_W(DEN_W)
	) u_weights (
		.clk    (clk),
		.en     (en),
		.pixel_x(pixel.pixel_x),
		.pixel_y(pixel.pixel_y),
		.span_w (span_w),
		.span_h (span_h),
		.wgt    (wgt),
		.den    (den_w)
	);

	bgpc_blend #(
		.DEN_W(DEN_W),
		.NUM_W(NUM_W)
	) u_blend (
		.clk    (clk),
		.en     (en),
		.corners(corners),
		.wgt    (wgt),
		.den    (den_w),
		.num    (num),
		.den_out(den_b)
	);

	bgpc_div #(
		.DEN_W(DEN_W),
		.NUM_W(NUM_W)
	) u_div (
		.clk(clk),
		.en (en),
		.num(num),
		.den(den_b),
		.quo(quo)
	);

	// freeze every pipeline stage while the skid register holds a result
	assign en          = !skid_vld_q;
	assign pixel.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], pixel.valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (color.ready)
				skid_vld_q <= 1'b0;
		end else if (vld_q[NST-1] && !color.ready) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_vld_q && vld_q[NST-1] && !color.ready)
			skid_rgb_q <= quo;
	end

	assign color.valid = skid_vld_q || vld_q[NST-1];
	assign color.red   = skid_vld_q ? skid_rgb_q[0] : quo[0];
	assign color.green = skid_vld_q ? skid_rgb_q[1] : quo[1];
	assign color.blue  = skid_vld_q ? skid_rgb_q[2] : quo[2];

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel.valid && pixel.ready) |=> vld_q[0])
		else $error("accepted pixel did not enter the first stage");

	a_stall_fills_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NST-1] && !skid_vld_q && !color.ready) |=> skid_vld_q)
		else $error("stalled result was not caught in the skid register");

	a_skid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_vld_q && !color.ready) |=> (skid_vld_q && $stable(skid_rgb_q)))
		else $error("skid register changed while the output stalled");

endmodule

FILE: verif/bgpc_checker.sv
`timescale 1ns / 1ps

module bgpc_checker (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	input  logic                                   cfg_ready,
	input  bgpc_pkg::cfg_idx_t                     cfg_index,
	input  logic [bgpc_pkg::COLOR_W-1:0]           cfg_data,
	input  logic                                   pixel_valid,
	input  logic                                   pixel_ready,
	input  logic [bgpc_pkg::COORD_W-1:0]           pixel_x,
	input  logic [bgpc_pkg::COORD_W-1:0]           pixel_y,
	input  logic                                   color_valid,
	input  logic                                   color_ready,
	input  logic [bgpc_pkg::CHAN_W-1:0]            red,
	input  logic [bgpc_pkg::CHAN_W-1:0]            green,
	input  logic [bgpc_pkg::CHAN_W-1:0]            blue,
	output int                                     pending_colors,
	output int                                     mismatch_count
);

	typedef struct packed {
		logic [bgpc_pkg::CHAN_W-1:0] red;
		logic [bgpc_pkg::CHAN_W-1:0] green;
		logic [bgpc_pkg::CHAN_W-1:0] blue;
	} rgb_t;

	// corner colors indexed by their register number
	logic [bgpc_pkg::COLOR_W-1:0] corner_color [bgpc_pkg::NUM_CORN];
	logic [bgpc_pkg::SIZE_W-1:0]  pix_cols;
	logic [bgpc_pkg::SIZE_W-1:0]  pix_rows;
	rgb_t                         expected_colors [$];

	function automatic longint unsigned size_span(logic [bgpc_pkg::SIZE_W-1:0] size,
			int limit);
		longint unsigned s;
		s = size;
		if (s == 0) s = 1;
		if (s > limit) s = limit;
		return s - 1;
	endfunction

	function automatic rgb_t blend_pixel_color(logic [bgpc_pkg::COORD_W-1:0] px,
			logic [bgpc_pkg::COORD_W-1:0] py);
		longint unsigned w1, h1, x, y, den, num, q;
		int              sh;
		rgb_t            c;
		w1 = size_span(pix_cols, bgpc_pkg::MAX_WIDTH_DEF);
		h1 = size_span(pix_rows, bgpc_pkg::MAX_HEIGHT_DEF);
		x = px;
		y = py;
		if (x > w1) x = w1;
		if (y > h1) y = h1;
		// a span of zero pins the coordinate at 0, so divide by 1 and keep the first end
		if (w1 == 0) w1 = 1;
		if (h1 == 0) h1 = 1;
		den = w1 * h1;
		for (int k = 0; k < bgpc_pkg::NUM_CH; k++) begin
			sh = 16 - 8 * k;
			num = corner_color[bgpc_pkg::REG_TOP_LEFT][sh +: 8] * (w1 - x) * (h1 - y)
				+ corner_color[bgpc_pkg::REG_TOP_RIGHT][sh +: 8] * x * (h1 - y)
				+ corner_color[bgpc_pkg::REG_BOTTOM_LEFT][sh +: 8] * (w1 - x) * y
				+ corner_color[bgpc_pkg::REG_BOTTOM_RIGHT][sh +: 8] * x * y;
			// round half up
			q = (num + den / 2) / den;
			if (q > 255) q = 255;
			c[sh +: 8] = q[7:0];
		end
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rgb_t got, want;
		int   sh;
		int   errs;
		if (!arst_n) begin
			corner_color[bgpc_pkg::REG_TOP_LEFT]     = bgpc_pkg::RST_TOP_LEFT;
			corner_color[bgpc_pkg::REG_TOP_RIGHT]    = bgpc_pkg::RST_TOP_RIGHT;
			corner_color[bgpc_pkg::REG_BOTTOM_LEFT]  = bgpc_pkg::RST_BOTTOM_LEFT;
			corner_color[bgpc_pkg::REG_BOTTOM_RIGHT] = bgpc_pkg::RST_BOTTOM_RIGHT;
			pix_cols = bgpc_pkg::RST_WIDTH;
			pix_rows = bgpc_pkg::RST_HEIGHT;
			expected_colors.delete();
			mismatch_count <= 0;
			pending_colors <= 0;
		end else begin
			errs = 0;
			if (color_valid && color_ready) begin
				got = '{red: red, green: green, blue: blue};
				if (expected_colors.size() == 0) begin
					$error("color request with no pixel outstanding: %0d %0d %0d",
						red, green, blue);
					errs++;
				end else begin
					want = expected_colors.pop_front();
					for (int k = 0; k < bgpc_pkg::NUM_CH; k++) begin
						sh = 16 - 8 * k;
						if (got[sh +: 8] !== want[sh +: 8]) begin
							$error("%s: expected %0d, got %0d",
								k == 0 ? "red" : (k == 1 ? "green" : "blue"),
								want[sh +: 8], got[sh +: 8]);
							errs++;
						end
					end
				end
			end
			if (pixel_valid && pixel_ready)
				expected_colors.push_back(blend_pixel_color(pixel_x, pixel_y));
			// registers only change while no pixel is in flight
			if (cfg_valid && cfg_ready) begin
				case (cfg_index) inside
					bgpc_pkg::REG_TOP_LEFT, bgpc_pkg::REG_TOP_RIGHT,
					bgpc_pkg::REG_BOTTOM_LEFT, bgpc_pkg::REG_BOTTOM_RIGHT: begin
						corner_color[cfg_index[1:0]] = cfg_data;
					end
					bgpc_pkg::REG_WIDTH: begin
						pix_cols = cfg_data[bgpc_pkg::SIZE_W-1:0];
					end
					bgpc_pkg::REG_HEIGHT: begin
						pix_rows = cfg_data[bgpc_pkg::SIZE_W-1:0];
					end
					default: begin
					end
				endcase
			end
			mismatch_count <= mismatch_count + errs;
			pending_colors <= expected_colors.size();
		end
	end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam bgpc_pkg::cfg_idx_t REG_SPARE_A = 3'd6;
	localparam bgpc_pkg::cfg_idx_t REG_SPARE_B = 3'd7;
	localparam int                 RANDOM_PHASES = 12;
	localparam int                 PHASE_PIXELS  = 61;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   steady_flow = 1'b0;
	int   pending_colors;
	int   mismatch_count;

	bgpc_pixel_if pix_if ();
	bgpc_color_if col_if ();
	bgpc_cfg_if   cfg_if ();

	bilinear_gradient_pixel_color_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pix_if),
		.color  (col_if),
		.cfg    (cfg_if)
	);

	bgpc_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_if.valid),
		.cfg_ready      (cfg_if.ready),
		.cfg_index      (cfg_if.index),
		.cfg_data       (cfg_if.data),
		.pixel_valid    (pix_if.valid),
		.pixel_ready    (pix_if.ready),
		.pixel_x        (pix_if.pixel_x),
		.pixel_y        (pix_if.pixel_y),
		.color_valid    (col_if.valid),
		.color_ready    (col_if.ready),
		.red            (col_if.red),
		.green          (col_if.green),
		.blue           (col_if.blue),
		.pending_colors (pending_colors),
		.mismatch_count (mismatch_count)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// color sink: unless in steady flow, stall for a random gap before taking each request
	initial begin
		int gap;
		col_if.ready = 1'b0;
		@(negedge clk);
		forever begin
			gap = steady_flow ? 0 : $urandom_range(0, 10);
			if (gap > 0) begin
				col_if.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			col_if.ready = 1'b1;
			do @(posedge clk); while (!col_if.valid);
			@(negedge clk);
		end
	end

	task automatic write_reg(bgpc_pkg::cfg_idx_t idx,
			logic [bgpc_pkg::COLOR_W-1:0] value);
		cfg_if.index = idx;
		cfg_if.data  = value;
		cfg_if.valid = 1'b1;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid = 1'b0;
	endtask

	task automatic send_pixel(logic [bgpc_pkg::COORD_W-1:0] x,
			logic [bgpc_pkg::COORD_W-1:0] y);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			pix_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_if.pixel_x = x;
		pix_if.pixel_y = y;
		pix_if.valid   = 1'b1;
		do @(posedge clk); while (!pix_if.ready);
		@(negedge clk);
	endtask

	// hold off until every pixel sent has come back as a color
	task automatic wait_idle();
		pix_if.valid = 1'b0;
		while (pending_colors != 0) @(negedge clk);
	endtask

	// sizes carry random junk in the unused upper data bits
	task automatic load_settings(logic [bgpc_pkg::COLOR_W-1:0] tl,
			logic [bgpc_pkg::COLOR_W-1:0] tr,
			logic [bgpc_pkg::COLOR_W-1:0] bl, logic [bgpc_pkg::COLOR_W-1:0] br,
			logic [bgpc_pkg::SIZE_W-1:0] w, logic [bgpc_pkg::SIZE_W-1:0] h);
		wait_idle();
		write_reg(bgpc_pkg::REG_TOP_LEFT, tl);
		write_reg(bgpc_pkg::REG_TOP_RIGHT, tr);
		write_reg(bgpc_pkg::REG_BOTTOM_LEFT, bl);
		write_reg(bgpc_pkg::REG_BOTTOM_RIGHT, br);
		write_reg(bgpc_pkg::REG_WIDTH, {11'($urandom), w});
		write_reg(bgpc_pkg::REG_HEIGHT, {11'($urandom), h});
	endtask

	function automatic logic [bgpc_pkg::SIZE_W-1:0] pick_size();
		int sel;
		sel = $urandom_range(0, 9);
		case (sel) inside
			0: begin
				case ($urandom_range(0, 5))
					0: return 13'd0;
					1: return 13'd1;
					2: return 13'd2;
					3: return 13'd4096;
					4: return 13'd4097;
					default: return 13'd8191;
				endcase
			end
			1, 2: return bgpc_pkg::SIZE_W'($urandom_range(0, 8191));
			default: return bgpc_pkg::SIZE_W'($urandom_range(1, 32));
		endcase
	endfunction

	function automatic logic [bgpc_pkg::COORD_W-1:0] pick_coord(
			logic [bgpc_pkg::SIZE_W-1:0] size);
		int lim;
		lim = (size == 0) ? 1 : ((size > 4096) ? 4096 : int'(size));
		case ($urandom_range(0, 7))
			0: return bgpc_pkg::COORD_W'($urandom);
			1: return bgpc_pkg::COORD_W'(lim - 1);
			default: return bgpc_pkg::COORD_W'($urandom_range(0, lim - 1));
		endcase
	endfunction

	initial begin
		logic [bgpc_pkg::SIZE_W-1:0] w, h;
		pix_if.valid   = 1'b0;
		pix_if.pixel_x = '0;
		pix_if.pixel_y = '0;
		cfg_if.valid   = 1'b0;
		cfg_if.index   = bgpc_pkg::REG_TOP_LEFT;
		cfg_if.data    = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset defaults: corners, center, and coordinates past the edges
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd639, 12'd0);
		send_pixel(12'd0, 12'd479);
		send_pixel(12'd639, 12'd479);
		send_pixel(12'd320, 12'd240);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd0, 12'd4095);

		// single column and row: always the top-left corner
		load_settings(24'h123456, 24'hABCDEF, 24'h00FF00, 24'hFF00FF, 13'd1, 13'd1);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd5, 12'd7);
		send_pixel(12'd4095, 12'd4095);

		// zero size acts as one
		load_settings(24'h00FF80, 24'h804020, 24'hFFFFFF, 24'h000000, 13'd0, 13'd0);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1, 12'd1);

		// oversized screen clamps to the maximum, full-scale corners
		load_settings(24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF, 13'd8191, 13'd4097);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd2048, 12'd2048);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd2047, 12'd2048);

		// divisor of two: odd sums land exactly halfway; spare indexes are dropped
		load_settings(24'h010203, 24'h000000, 24'h000000, 24'h000000, 13'd3, 13'd2);
		write_reg(REG_SPARE_A, 24'($urandom));
		write_reg(REG_SPARE_B, 24'($urandom));
		send_pixel(12'd1, 12'd0);
		send_pixel(12'd1, 12'd1);
		send_pixel(12'd2, 12'd1);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			steady_flow = 1'b0;
			w = pick_size();
			h = pick_size();
			load_settings(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom), w, h);
			if (phase % 3 == 2)
				write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 24'($urandom));
			steady_flow = (phase % 4 == 1);
			for (int n = 0; n < PHASE_PIXELS; n++) begin
				// brief runs with no idling inside the other phases too
				if (phase % 4 != 1)
					steady_flow = ($urandom_range(0, 15) == 0) ? ~steady_flow : steady_flow;
				send_pixel(pick_coord(w), pick_coord(h));
			end
		end

		steady_flow = 1'b0;
		wait_idle();
		repeat (20) @(negedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: files.f
design/bgpc_pkg.sv
design/bgpc_ifs.sv
design/bgpc_cfg_regs.sv
design/bgpc_weights.sv
design/bgpc_blend.sv
design/bgpc_div.sv
design/bilinear_gradient_pixel_color_unit.sv
verif/bgpc_checker.sv
verif/testbench.sv
